[rtl/tfst_pkg.sv]
// Package for the TCP flow state tracker.
// Holds the flag bit positions, the one-hot peer state type, the timeout
// register set and the code conversion shared by every module of the block.
package tfst_pkg;

    localparam int FLAGS_W   = 8;
    localparam int STCODE_W  = 4;
    localparam int TIMEOUT_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 2 * STCODE_W + 2 * TIMEOUT_W;

    // Bit positions in the TCP flag byte.
    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_RST_BIT = 2;
    localparam int FLAG_ACK_BIT = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ESTABLISHED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_SENT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_RECEIVED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIN_WAIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WAIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED       = 3'd5;

    // Timeout values after reset, in seconds.
    localparam logic [TIMEOUT_W-1:0] RST_ESTABLISHED  = 20'd7440;
    localparam logic [TIMEOUT_W-1:0] RST_SYN_SENT     = 20'd120;
    localparam logic [TIMEOUT_W-1:0] RST_SYN_RECEIVED = 20'd60;
    localparam logic [TIMEOUT_W-1:0] RST_FIN_WAIT     = 20'd120;
    localparam logic [TIMEOUT_W-1:0] RST_TIME_WAIT    = 20'd120;
    localparam logic [TIMEOUT_W-1:0] RST_CLOSED       = 20'd10;

    // External state codes.
    localparam logic [STCODE_W-1:0] CODE_CLOSED      = 4'd0;
    localparam logic [STCODE_W-1:0] CODE_SYN_SENT    = 4'd1;
    localparam logic [STCODE_W-1:0] CODE_SYN_RCVD    = 4'd2;
    localparam logic [STCODE_W-1:0] CODE_ESTABLISHED = 4'd3;
    localparam logic [STCODE_W-1:0] CODE_FIN_WAIT1   = 4'd4;
    localparam logic [STCODE_W-1:0] CODE_FIN_WAIT2   = 4'd5;
    localparam logic [STCODE_W-1:0] CODE_CLOSING     = 4'd6;
    localparam logic [STCODE_W-1:0] CODE_TIME_WAIT   = 4'd7;
    localparam logic [STCODE_W-1:0] CODE_CLOSE_WAIT  = 4'd8;
    localparam logic [STCODE_W-1:0] CODE_LAST_ACK    = 4'd9;

    // Peer connection state, one-hot.
    typedef enum logic [9:0] {
        ST_CLOSED      = 10'b00_0000_0001,
        ST_SYN_SENT    = 10'b00_0000_0010,
        ST_SYN_RCVD    = 10'b00_0000_0100,
        ST_ESTABLISHED = 10'b00_0000_1000,
        ST_FIN_WAIT1   = 10'b00_0001_0000,
        ST_FIN_WAIT2   = 10'b00_0010_0000,
        ST_CLOSING     = 10'b00_0100_0000,
        ST_TIME_WAIT   = 10'b00_1000_0000,
        ST_CLOSE_WAIT  = 10'b01_0000_0000,
        ST_LAST_ACK    = 10'b10_0000_0000
    } peer_state_t;

    // The full set of configured timeouts.
    typedef struct packed {
        logic [TIMEOUT_W-1:0] established;
        logic [TIMEOUT_W-1:0] syn_sent;
        logic [TIMEOUT_W-1:0] syn_received;
        logic [TIMEOUT_W-1:0] fin_wait;
        logic [TIMEOUT_W-1:0] time_wait;
        logic [TIMEOUT_W-1:0] closed;
    } timeouts_t;

    // Flow state as held by the top level and produced by the transition logic.
    typedef struct packed {
        peer_state_t          initiator;
        peer_state_t          responder;
        logic [TIMEOUT_W-1:0] expiry;
    } flow_state_t;

    // Converts a one-hot peer state to its external code.
    function automatic logic [STCODE_W-1:0] state_code(input peer_state_t st);
        logic [STCODE_W-1:0] code;
        case (st)
            ST_CLOSED:      code = CODE_CLOSED;
            ST_SYN_SENT:    code = CODE_SYN_SENT;
            ST_SYN_RCVD:    code = CODE_SYN_RCVD;
            ST_ESTABLISHED: code = CODE_ESTABLISHED;
            ST_FIN_WAIT1:   code = CODE_FIN_WAIT1;
            ST_FIN_WAIT2:   code = CODE_FIN_WAIT2;
            ST_CLOSING:     code = CODE_CLOSING;
            ST_TIME_WAIT:   code = CODE_TIME_WAIT;
            ST_CLOSE_WAIT:  code = CODE_CLOSE_WAIT;
            ST_LAST_ACK:    code = CODE_LAST_ACK;
            default:        code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

[rtl/tfst_cfg_regs.sv]
// Timeout configuration registers of the TCP flow state tracker.
// Depends on tfst_pkg for the register indexes and reset values.
module tfst_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tfst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfst_pkg::TIMEOUT_W-1:0] cfg_data,
    output tfst_pkg::timeouts_t            timeouts
);
    import tfst_pkg::*;

    timeouts_t timeouts_reg;

    // Each write lands in its register at once, so the channel is always ready.
    assign cfg_ready = 1'b1;
    assign timeouts  = timeouts_reg;

    // Register file; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeouts_reg.established  <= RST_ESTABLISHED;
            timeouts_reg.syn_sent     <= RST_SYN_SENT;
            timeouts_reg.syn_received <= RST_SYN_RECEIVED;
            timeouts_reg.fin_wait     <= RST_FIN_WAIT;
            timeouts_reg.time_wait    <= RST_TIME_WAIT;
            timeouts_reg.closed       <= RST_CLOSED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ESTABLISHED:  timeouts_reg.established  <= cfg_data;
                REG_SYN_SENT:     timeouts_reg.syn_sent     <= cfg_data;
                REG_SYN_RECEIVED: timeouts_reg.syn_received <= cfg_data;
                REG_FIN_WAIT:     timeouts_reg.fin_wait     <= cfg_data;
                REG_TIME_WAIT:    timeouts_reg.time_wait    <= cfg_data;
                REG_CLOSED:       timeouts_reg.closed       <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

[rtl/tfst_transition.sv]
// Next-state decode of the TCP flow state tracker: one segment's flags move
// the peer states and the expiry. Depends on tfst_pkg.
module tfst_transition (
    input  logic [tfst_pkg::FLAGS_W-1:0]   tcp_flags,
    input  logic                           from_initiator,
    input  tfst_pkg::flow_state_t          cur,
    input  tfst_pkg::timeouts_t            timeouts,
    output tfst_pkg::flow_state_t          nxt,
    output logic [tfst_pkg::TIMEOUT_W-1:0] selected_timeout
);
    import tfst_pkg::*;

    logic        fin;
    logic        syn;
    logic        rst;
    logic        ack;
    peer_state_t snd;
    peer_state_t rcv;
    peer_state_t snd_next;
    peer_state_t rcv_next;
    logic [TIMEOUT_W-1:0] expiry_next;

    assign fin = tcp_flags[FLAG_FIN_BIT];
    assign syn = tcp_flags[FLAG_SYN_BIT];
    assign rst = tcp_flags[FLAG_RST_BIT];
    assign ack = tcp_flags[FLAG_ACK_BIT];

    // The segment's sender and receiver, by direction.
    assign snd = from_initiator ? cur.initiator : cur.responder;
    assign rcv = from_initiator ? cur.responder : cur.initiator;

    // Next sender, receiver and expiry; reset wins over every other flag.
    always_comb
    begin
        snd_next    = snd;
        rcv_next    = rcv;
        expiry_next = cur.expiry;
        if (rst)
        begin
            snd_next    = ST_CLOSED;
            rcv_next    = ST_CLOSED;
            expiry_next = timeouts.closed;
        end
        else
        begin
            case (snd)
                ST_CLOSED, ST_SYN_SENT:
                begin
                    if (syn && !ack)
                    begin
                        snd_next    = ST_SYN_SENT;
                        expiry_next = timeouts.syn_sent;
                    end
                    else if (syn && ack)
                    begin
                        snd_next    = ST_SYN_RCVD;
                        expiry_next = timeouts.syn_received;
                    end
                end
                ST_SYN_RCVD:
                begin
                    if (ack)
                    begin
                        snd_next    = ST_ESTABLISHED;
                        rcv_next    = ST_ESTABLISHED;
                        expiry_next = timeouts.established;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if (fin)
                    begin
                        snd_next    = ST_FIN_WAIT1;
                        expiry_next = timeouts.fin_wait;
                    end
                end
                ST_FIN_WAIT1:
                begin
                    // FIN with ACK goes to closing; a bare ACK keeps the expiry.
                    if (fin && ack)
                    begin
                        snd_next    = ST_CLOSING;
                        expiry_next = timeouts.fin_wait;
                    end
                    else if (ack)
                    begin
                        snd_next = ST_FIN_WAIT2;
                    end
                    else if (fin)
                    begin
                        snd_next    = ST_TIME_WAIT;
                        expiry_next = timeouts.time_wait;
                    end
                end
                ST_FIN_WAIT2:
                begin
                    if (fin)
                    begin
                        snd_next    = ST_TIME_WAIT;
                        expiry_next = timeouts.time_wait;
                    end
                end
                ST_CLOSING:
                begin
                    if (ack)
                    begin
                        snd_next    = ST_TIME_WAIT;
                        expiry_next = timeouts.time_wait;
                    end
                end
                ST_CLOSE_WAIT:
                begin
                    if (fin)
                    begin
                        snd_next    = ST_LAST_ACK;
                        expiry_next = timeouts.fin_wait;
                    end
                end
                ST_LAST_ACK:
                begin
                    if (ack)
                    begin
                        snd_next    = ST_CLOSED;
                        rcv_next    = ST_CLOSED;
                        expiry_next = timeouts.closed;
                    end
                end
                // A sender in time-wait does not move.
                default: ;
            endcase
        end
    end

    // Map sender and receiver back onto the two peers.
    assign nxt.initiator = from_initiator ? snd_next : rcv_next;
    assign nxt.responder = from_initiator ? rcv_next : snd_next;
    assign nxt.expiry    = expiry_next;

    // Timeout chosen by the initiator's new state.
    always_comb
    begin
        case (nxt.initiator)
            ST_ESTABLISHED: selected_timeout = timeouts.established;
            ST_SYN_SENT:    selected_timeout = timeouts.syn_sent;
            ST_SYN_RCVD:    selected_timeout = timeouts.syn_received;
            ST_TIME_WAIT:   selected_timeout = timeouts.time_wait;
            ST_CLOSED:      selected_timeout = timeouts.closed;
            default:        selected_timeout = timeouts.fin_wait;
        endcase
    end

endmodule

[rtl/tcp_flow_state_tracker.sv]
// TCP flow state tracker, top level: flow state registers, result register.
// Result of an accepted segment: registered, on m_tdata in the next cycle.
// Throughput: one segment per cycle unless m_tready stalls the output register.
// Reset: asynchronous, active low; both peers Closed, expiry 0, timeouts at
// their defaults. Depends on tfst_pkg, tfst_cfg_regs and tfst_transition.
module tcp_flow_state_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    // Segment input. s_tdata: tcp_flags[7:0]. s_tuser: from_initiator[0].
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tfst_pkg::FLAGS_W-1:0]   s_tdata,
    input  logic [0:0]                     s_tuser,
    // Result output. m_tdata: initiator_state[3:0], responder_state[7:4],
    // expiry_seconds[27:8], selected_timeout[47:28].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tfst_pkg::OUT_W-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tfst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfst_pkg::TIMEOUT_W-1:0] cfg_data
);
    import tfst_pkg::*;

    timeouts_t            timeouts;
    flow_state_t          flow_reg;
    flow_state_t          flow_next;
    logic [TIMEOUT_W-1:0] selected_timeout;
    logic                 in_fire;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    tfst_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timeouts  (timeouts)
    );

    tfst_transition u_transition (
        .tcp_flags        (s_tdata),
        .from_initiator   (s_tuser[0]),
        .cur              (flow_reg),
        .timeouts         (timeouts),
        .nxt              (flow_next),
        .selected_timeout (selected_timeout)
    );

    // A new segment is taken whenever the result register is free or emptying.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Flow state advances on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg.initiator <= ST_CLOSED;
            flow_reg.responder <= ST_CLOSED;
            flow_reg.expiry    <= '0;
        end
        else if (in_fire)
        begin
            flow_reg <= flow_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Result payload, packed from the lowest field up.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {selected_timeout, flow_next.expiry,
                             state_code(flow_next.responder),
                             state_code(flow_next.initiator)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // A segment with RST leaves both peers closed.
    a_rst_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tdata[FLAG_RST_BIT] |=>
            flow_reg.initiator == ST_CLOSED && flow_reg.responder == ST_CLOSED)
        else $error("RST segment did not close both peers");

    // Every accepted segment yields a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_tvalid)
        else $error("accepted segment produced no result");

    // While a result is stalled, the flow state must not move.
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(flow_reg))
        else $error("flow state changed while result was stalled");
`endif

endmodule
